### hw/rtl/lrupr_pkg.sv
// Shared constants, types and helpers for the LRU page replacement unit.
`default_nettype none

package lrupr_pkg;

	// Built table size and stored page width.
	localparam int FRAMES = 8;
	localparam int PAGE_W = 16;

	// Frame index and recency rank widths; ranks of valid frames stay below FRAMES.
	localparam int IDX_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int RANK_W = IDX_W;
	// Width able to hold the active frame count itself.
	localparam int CNT_W  = $clog2(FRAMES + 1);

	// Fixed field widths of the channels.
	localparam int PAGE_NUM_W  = 16;
	localparam int FRAME_OUT_W = 3;
	localparam int FAULT_W     = 16;
	localparam int CFG_W       = 4;

	localparam logic [FAULT_W-1:0] FAULT_MAX = {FAULT_W{1'b1}};
	localparam logic [CFG_W-1:0]   CFG_RESET = CFG_W'(8);

	// Lookup word broadcast to every cell for the current reference.
	typedef struct packed {
		logic              clear;
		logic [PAGE_W-1:0] page;
	} lookup_t;

	// Search results handed from one cell to the next along the row.
	typedef struct packed {
		logic              hit_found;
		logic [IDX_W-1:0]  hit_idx;
		logic [RANK_W-1:0] hit_rank;
		logic              empty_found;
		logic [IDX_W-1:0]  empty_idx;
		logic              vic_found;
		logic [IDX_W-1:0]  vic_idx;
		logic [RANK_W-1:0] vic_rank;
		logic [PAGE_W-1:0] vic_page;
	} chain_t;

	// Update broadcast to every cell when a reference is accepted.
	typedef struct packed {
		logic              en;
		logic [IDX_W-1:0]  slot;
		logic              hit;
		logic              was_valid;
		logic [RANK_W-1:0] old_rank;
		logic [PAGE_W-1:0] page;
	} commit_t;

	// Frame index as it appears on the result port.
	function automatic logic [FRAME_OUT_W-1:0] to_frame_index(input logic [IDX_W-1:0] idx);
		logic [31:0] wide;
		wide = 32'(idx);
		return wide[FRAME_OUT_W-1:0];
	endfunction

endpackage

`default_nettype wire

### hw/rtl/lrupr_if.sv
// Handshake channel interfaces for the reference, result and configuration words.
`default_nettype none

// Page reference channel.
interface lrupr_req_if;
	logic        valid;
	logic        ready;
	logic [15:0] page_number;
	logic        first_of_string;
	logic        end_of_string;

	modport source (output valid, page_number, first_of_string, end_of_string, input ready);
	modport sink   (input valid, page_number, first_of_string, end_of_string, output ready);
endinterface

// Result channel.
interface lrupr_rsp_if;
	logic        valid;
	logic        ready;
	logic        hit;
	logic [2:0]  frame_index;
	logic        evicted_valid;
	logic [15:0] evicted_page;
	logic [15:0] fault_total;
	logic        final_res;

	modport source (output valid, hit, frame_index, evicted_valid, evicted_page, fault_total,
		final_res, input ready);
	modport sink   (input valid, hit, frame_index, evicted_valid, evicted_page, fault_total,
		final_res, output ready);
endinterface

// Frame count register write channel.
interface lrupr_cfg_if;
	logic       valid;
	logic       ready;
	logic [3:0] frame_count;

	modport source (output valid, frame_count, input ready);
	modport sink   (input valid, frame_count, output ready);
endinterface

`default_nettype wire

### hw/rtl/lrupr_cell.sv
// One frame of the table: page, valid bit and recency rank, with its search step.
`default_nettype none

module lrupr_cell (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire  [lrupr_pkg::IDX_W-1:0]      cell_idx,
	input  wire                              active,
	input  lrupr_pkg::lookup_t               lookup,
	input  lrupr_pkg::chain_t                chain_in,
	output lrupr_pkg::chain_t                chain_out,
	input  lrupr_pkg::commit_t               commit
);

	logic                           valid_q;
	logic [lrupr_pkg::PAGE_W-1:0]   page_q;
	logic [lrupr_pkg::RANK_W-1:0]   rank_q;
	logic                           eff_valid;
	logic                           is_slot;

	// A clearing reference sees the frame as empty.
	assign eff_valid = valid_q & ~lookup.clear;
	assign is_slot   = (commit.slot == cell_idx);

	// Search step: first hit, first empty frame and oldest valid frame so far.
	always_comb begin
		chain_out = chain_in;
		if (active && eff_valid && (page_q == lookup.page) && !chain_in.hit_found) begin
			chain_out.hit_found = 1'b1;
			chain_out.hit_idx   = cell_idx;
			chain_out.hit_rank  = rank_q;
		end
		if (active && !eff_valid && !chain_in.empty_found) begin
			chain_out.empty_found = 1'b1;
			chain_out.empty_idx   = cell_idx;
		end
		if (active && eff_valid && (!chain_in.vic_found || (rank_q > chain_in.vic_rank))) begin
			chain_out.vic_found = 1'b1;
			chain_out.vic_idx   = cell_idx;
			chain_out.vic_rank  = rank_q;
			chain_out.vic_page  = page_q;
		end
	end

	// Valid bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (commit.en) begin
			valid_q <= is_slot | eff_valid;
		end
	end

	// Page and rank; ranks younger than the touched frame age by one.
	always_ff @(posedge clk) begin
		if (commit.en) begin
			if (is_slot) begin
				rank_q <= '0;
				if (!commit.hit) begin
					page_q <= commit.page;
				end
			end else if (eff_valid && (!commit.was_valid || (rank_q < commit.old_rank))) begin
				rank_q <= rank_q + 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

### hw/rtl/lru_page_replacement_unit.sv
// Top level of the LRU page replacement unit: cell row, fault counter and result register.
//
//   channel | modport | word                                          | accepted when
//   req     | sink    | page_number, first_of_string, end_of_string   | valid && ready
//   rsp     | source  | hit, frame_index, evicted_*, fault_total, ... | valid && ready
//   cfg     | sink    | frame_count                                   | valid && ready
//
// One reference per cycle if not stalled; its result is registered, on rsp the cycle after.
// The cycle is bounded by the search rippling through the row of frame cells.
// Reset empties every frame, clears the fault count and sets frame_count to 8.
// req.ready drops only while a result waits on rsp with rsp.ready low.
// cfg.ready is always high.
`default_nettype none

module lru_page_replacement_unit (
	input  wire         clk,
	input  wire         arst_n,
	lrupr_req_if.sink   req,
	lrupr_rsp_if.source rsp,
	lrupr_cfg_if.sink   cfg
);

	localparam int FRAMES = lrupr_pkg::FRAMES;

	logic [lrupr_pkg::CFG_W-1:0]     frame_count_q;
	logic [lrupr_pkg::CNT_W-1:0]     active_cnt;
	logic [FRAMES-1:0]               active_mask;
	logic                            accept;
	lrupr_pkg::lookup_t              lookup;
	lrupr_pkg::chain_t               chain [FRAMES+1];
	lrupr_pkg::chain_t               found;
	lrupr_pkg::commit_t              commit;
	logic [lrupr_pkg::FAULT_W-1:0]   fault_q;
	logic [lrupr_pkg::FAULT_W-1:0]   fault_base;
	logic [lrupr_pkg::FAULT_W-1:0]   fault_next;
	logic                            evict;

	logic                               rsp_valid_q;
	logic                               hit_q;
	logic [lrupr_pkg::FRAME_OUT_W-1:0]  frame_index_q;
	logic                               evicted_valid_q;
	logic [lrupr_pkg::PAGE_NUM_W-1:0]   evicted_page_q;
	logic [lrupr_pkg::FAULT_W-1:0]      fault_total_q;
	logic                               final_res_q;

	// Configuration register.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_count_q <= lrupr_pkg::CFG_RESET;
		end else if (cfg.valid) begin
			frame_count_q <= cfg.frame_count;
		end
	end

	// Active frame count, zero taken as one and capped at the built size.
	always_comb begin
		if (frame_count_q == '0) begin
			active_cnt = lrupr_pkg::CNT_W'(1);
		end else if (32'(frame_count_q) > FRAMES) begin
			active_cnt = lrupr_pkg::CNT_W'(FRAMES);
		end else begin
			active_cnt = lrupr_pkg::CNT_W'(frame_count_q);
		end
	end

	// Input handshake.
	assign req.ready = ~rsp_valid_q | rsp.ready;
	assign accept    = req.valid & req.ready;

	assign lookup.clear = req.first_of_string;
	assign lookup.page  = lrupr_pkg::PAGE_W'(req.page_number);

	// Row of frame cells; the search word enters at frame zero.
	assign chain[0] = '0;

	for (genvar i = 0; i < FRAMES; i++) begin : g_cell
		assign active_mask[i] = (lrupr_pkg::CNT_W'(i) < active_cnt);

		lrupr_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cell_idx  (lrupr_pkg::IDX_W'(i)),
			.active    (active_mask[i]),
			.lookup    (lookup),
			.chain_in  (chain[i]),
			.chain_out (chain[i+1]),
			.commit    (commit)
		);
	end

	assign found = chain[FRAMES];
	assign evict = ~found.hit_found & ~found.empty_found;

	// Frame choice and the update handed back to the row.
	always_comb begin
		commit.en        = accept;
		commit.hit       = found.hit_found;
		commit.page      = lookup.page;
		commit.was_valid = found.hit_found | evict;
		commit.old_rank  = found.hit_found ? found.hit_rank : found.vic_rank;
		if (found.hit_found) begin
			commit.slot = found.hit_idx;
		end else if (found.empty_found) begin
			commit.slot = found.empty_idx;
		end else begin
			commit.slot = found.vic_idx;
		end
	end

	// Saturating fault count, restarted by a clearing reference.
	assign fault_base = req.first_of_string ? '0 : fault_q;

	always_comb begin
		if (found.hit_found || (fault_base == lrupr_pkg::FAULT_MAX)) begin
			fault_next = fault_base;
		end else begin
			fault_next = fault_base + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fault_q <= '0;
		end else if (accept) begin
			fault_q <= fault_next;
		end
	end

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (accept) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			hit_q           <= found.hit_found;
			frame_index_q   <= lrupr_pkg::to_frame_index(commit.slot);
			evicted_valid_q <= evict;
			evicted_page_q  <= evict ? lrupr_pkg::PAGE_NUM_W'(found.vic_page) : '0;
			fault_total_q   <= fault_next;
			final_res_q     <= req.end_of_string;
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.hit           = hit_q;
	assign rsp.frame_index   = frame_index_q;
	assign rsp.evicted_valid = evicted_valid_q;
	assign rsp.evicted_page  = evicted_page_q;
	assign rsp.fault_total   = fault_total_q;
	assign rsp.final_res     = final_res_q;

endmodule

`default_nettype wire

### hw/rtl/lrupr_checker.sv
// Port-level checks for the LRU page replacement unit, bound to its top level.
`default_nettype none

module lrupr_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        req_valid,
	input wire        req_ready,
	input wire        req_first,
	input wire        rsp_valid,
	input wire        rsp_ready,
	input wire        rsp_hit,
	input wire [2:0]  rsp_frame_index,
	input wire        rsp_evicted_valid,
	input wire [15:0] rsp_evicted_page,
	input wire [15:0] rsp_fault_total,
	input wire        rsp_final_res
);

	// A stalled result word holds.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hit)
			&& $stable(rsp_frame_index) && $stable(rsp_evicted_page)
			&& $stable(rsp_fault_total) && $stable(rsp_final_res))
		else $error("result word changed while stalled");

	// Every accepted reference gives a result on the next cycle.
	a_rsp_follows: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> rsp_valid)
		else $error("no result after an accepted reference");

	// A new result appears only after a reference was accepted.
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(req_valid && req_ready))
		else $error("result without a reference");

	// The first reference of a string always faults into an empty table.
	a_first_faults: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req_first |=> !rsp_hit && !rsp_evicted_valid
			&& (rsp_fault_total == 16'd1))
		else $error("first reference of a string did not fault once");

	// Without an eviction the evicted page reads zero.
	a_evict_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_evicted_valid |-> (rsp_evicted_page == 16'd0))
		else $error("evicted page set without an eviction");

endmodule

bind lru_page_replacement_unit lrupr_checker u_lrupr_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.req_valid         (req.valid),
	.req_ready         (req.ready),
	.req_first         (req.first_of_string),
	.rsp_valid         (rsp.valid),
	.rsp_ready         (rsp.ready),
	.rsp_hit           (rsp.hit),
	.rsp_frame_index   (rsp.frame_index),
	.rsp_evicted_valid (rsp.evicted_valid),
	.rsp_evicted_page  (rsp.evicted_page),
	.rsp_fault_total   (rsp.fault_total),
	.rsp_final_res     (rsp.final_res)
);

`default_nettype wire

### sim/tb_lru_page_replacement_unit.sv
`timescale 1ns / 100ps
// Testbench for the LRU page replacement unit, checked against a frame table predictor.
module tb_lru_page_replacement_unit;

	// One result word as the block should report it.
	typedef struct packed {
		logic                              hit;
		logic [lrupr_pkg::FRAME_OUT_W-1:0] frame_index;
		logic                              evicted_valid;
		logic [lrupr_pkg::PAGE_NUM_W-1:0]  evicted_page;
		logic [lrupr_pkg::FAULT_W-1:0]     fault_total;
		logic                              final_res;
	} lru_result_t;

	localparam int STALL_CYCLES = 300;
	localparam int RANDOM_ITEMS = 370;

	logic clk;
	logic arst_n;

	lrupr_req_if req_ch();
	lrupr_rsp_if rsp_ch();
	lrupr_cfg_if cfg_ch();

	lru_page_replacement_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.cfg(cfg_ch)
	);

	// Predicted frame table, recency ranks, fault count and frame count register.
	logic [lrupr_pkg::PAGE_W-1:0]  tbl_page [lrupr_pkg::FRAMES];
	bit                            tbl_valid [lrupr_pkg::FRAMES];
	int unsigned                   tbl_rank [lrupr_pkg::FRAMES];
	logic [lrupr_pkg::FAULT_W-1:0] tbl_faults;
	logic [lrupr_pkg::CFG_W-1:0]   tbl_frame_count;

	lru_result_t expected_results[$];
	int          mismatches;
	bit          gaps_on;
	bit          stall_req;
	bit          stall_taken;
	int          stall_left;

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// A hung run ends here.
	initial begin
		#200_000;
		$display("[lru_page_replacement_unit] ERROR");
		$finish;
	end

	// Empty every frame and restart the fault count.
	function automatic void clear_frames();
		int i;
		for (i = 0; i < lrupr_pkg::FRAMES; i++) begin
			tbl_page[i]  = '0;
			tbl_valid[i] = 1'b0;
			tbl_rank[i]  = 0;
		end
		tbl_faults = '0;
	endfunction

	// Look up one page reference, update the table and return the result word.
	function automatic lru_result_t predict_reference(
			input logic [lrupr_pkg::PAGE_NUM_W-1:0] pg, input logic fs, input logic es);
		lru_result_t                  r;
		logic [lrupr_pkg::PAGE_W-1:0] p;
		int                           active;
		int                           i;
		int                           slot;
		bit                           found;
		bit                           was_valid;
		int unsigned                  old_rank;
		p = pg[lrupr_pkg::PAGE_W-1:0];
		active = int'(tbl_frame_count);
		if (active == 0)
			active = 1;
		if (active > lrupr_pkg::FRAMES)
			active = lrupr_pkg::FRAMES;
		if (fs)
			clear_frames();
		r = '0;
		slot = 0;
		found = 1'b0;
		for (i = 0; i < active && !found; i++) begin
			if (tbl_valid[i] && tbl_page[i] == p) begin
				found = 1'b1;
				slot = i;
			end
		end
		r.hit = found;
		// On a fault, prefer the lowest empty frame, else the oldest active one.
		if (!found) begin
			for (i = 0; i < active && !found; i++) begin
				if (!tbl_valid[i]) begin
					found = 1'b1;
					slot = i;
				end
			end
			if (!found) begin
				slot = 0;
				for (i = 1; i < active; i++)
					if (tbl_rank[i] > tbl_rank[slot])
						slot = i;
				r.evicted_valid = 1'b1;
				r.evicted_page = lrupr_pkg::PAGE_NUM_W'(tbl_page[slot]);
			end
			tbl_page[slot] = p;
			if (tbl_faults != lrupr_pkg::FAULT_MAX)
				tbl_faults++;
		end
		// Make the chosen frame the most recent; only younger frames age on a hit.
		was_valid = tbl_valid[slot];
		old_rank = tbl_rank[slot];
		for (i = 0; i < lrupr_pkg::FRAMES; i++)
			if (i != slot && tbl_valid[i] && (!was_valid || tbl_rank[i] < old_rank))
				tbl_rank[i]++;
		tbl_rank[slot] = 0;
		tbl_valid[slot] = 1'b1;
		r.frame_index = lrupr_pkg::FRAME_OUT_W'(slot);
		r.fault_total = tbl_faults;
		r.final_res = es;
		return r;
	endfunction

	task automatic note_mismatch(input string what, input lru_result_t want,
			input lru_result_t got);
		mismatches++;
		if (mismatches <= 10)
			$display({"%0t %s: expected hit=%0d frame=%0d ev=%0d/%h faults=%0d final=%0d,",
				" got hit=%0d frame=%0d ev=%0d/%h faults=%0d final=%0d"},
				$realtime, what, want.hit, want.frame_index, want.evicted_valid,
				want.evicted_page, want.fault_total, want.final_res, got.hit,
				got.frame_index, got.evicted_valid, got.evicted_page, got.fault_total,
				got.final_res);
	endtask

	// Result receiver: random stalls, plus one long hold-off on request.
	always @(posedge clk) begin
		if (stall_req && !stall_taken) begin
			stall_taken = 1'b1;
			stall_left = STALL_CYCLES;
		end
		if (stall_left > 0) begin
			stall_left = stall_left - 1;
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= !(gaps_on && $urandom_range(0, 99) < 6);
		end
	end

	// Compare every accepted result word with the oldest prediction.
	always @(posedge clk) begin
		lru_result_t got;
		lru_result_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			got.hit = rsp_ch.hit;
			got.frame_index = rsp_ch.frame_index;
			got.evicted_valid = rsp_ch.evicted_valid;
			got.evicted_page = rsp_ch.evicted_page;
			got.fault_total = rsp_ch.fault_total;
			got.final_res = rsp_ch.final_res;
			if (expected_results.size() == 0) begin
				note_mismatch("unexpected result", got, got);
			end else begin
				want = expected_results.pop_front();
				if (got.hit != want.hit || got.frame_index != want.frame_index ||
						got.evicted_valid != want.evicted_valid ||
						got.evicted_page != want.evicted_page ||
						got.fault_total != want.fault_total || got.final_res != want.final_res)
					note_mismatch("result mismatch", want, got);
			end
		end
	end

	// Offer one reference word and record its prediction once accepted.
	task automatic send_ref(input logic [lrupr_pkg::PAGE_NUM_W-1:0] pg, input logic fs,
			input logic es);
		while (gaps_on && $urandom_range(0, 99) < 6) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.page_number <= pg;
		req_ch.first_of_string <= fs;
		req_ch.end_of_string <= es;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		expected_results.push_back(predict_reference(pg, fs, es));
	endtask

	// Stop offering and let every outstanding result come back.
	task automatic wait_idle();
		req_ch.valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// Write the frame count register; only called while the block is idle.
	task automatic write_frame_count(input logic [lrupr_pkg::CFG_W-1:0] v);
		cfg_ch.valid <= 1'b1;
		cfg_ch.frame_count <= v;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		cfg_ch.valid <= 1'b0;
		tbl_frame_count = v;
	endtask

	// Fill all frames at the reset frame count, hit, then evict the oldest pages.
	task automatic test_fill_hit_evict();
		send_ref(16'h0000, 1'b1, 1'b0);
		send_ref(16'hFFFF, 1'b0, 1'b0);
		send_ref(16'h5555, 1'b0, 1'b0);
		send_ref(16'hAAAA, 1'b0, 1'b0);
		send_ref(16'h0001, 1'b0, 1'b0);
		send_ref(16'h0002, 1'b0, 1'b0);
		send_ref(16'h0003, 1'b0, 1'b0);
		send_ref(16'h8000, 1'b0, 1'b0);
		send_ref(16'h0000, 1'b0, 1'b0);
		send_ref(16'h1234, 1'b0, 1'b0);
		send_ref(16'hFFFF, 1'b0, 1'b1);
		wait_idle();
	endtask

	// A frame count of zero acts as one frame; the largest value acts as the full table.
	task automatic test_frame_count_limits();
		int i;
		write_frame_count(lrupr_pkg::CFG_W'(0));
		send_ref(16'h0007, 1'b1, 1'b0);
		send_ref(16'h0007, 1'b0, 1'b0);
		send_ref(16'h0009, 1'b0, 1'b1);
		wait_idle();
		write_frame_count({lrupr_pkg::CFG_W{1'b1}});
		for (i = 0; i <= lrupr_pkg::FRAMES; i++)
			send_ref(lrupr_pkg::PAGE_NUM_W'(16'h0100 + i), i == 0, i == lrupr_pkg::FRAMES);
		wait_idle();
	endtask

	// Shrinking mid-string hides frames; growing again brings them back.
	task automatic test_resize_mid_string();
		write_frame_count(lrupr_pkg::CFG_W'(4));
		send_ref(16'h00A0, 1'b1, 1'b0);
		send_ref(16'h00A1, 1'b0, 1'b0);
		send_ref(16'h00A2, 1'b0, 1'b0);
		send_ref(16'h00A3, 1'b0, 1'b0);
		wait_idle();
		write_frame_count(lrupr_pkg::CFG_W'(2));
		send_ref(16'h00A2, 1'b0, 1'b0);
		wait_idle();
		write_frame_count(lrupr_pkg::CFG_W'(lrupr_pkg::FRAMES));
		send_ref(16'h00A3, 1'b0, 1'b1);
		wait_idle();
	endtask

	// The receiver holds off while references keep coming, so the input stalls.
	task automatic test_result_backpressure();
		int i;
		write_frame_count(lrupr_pkg::CFG_W'(3));
		stall_req = 1'b1;
		for (i = 0; i < 40; i++)
			send_ref(lrupr_pkg::PAGE_NUM_W'(16'h0200 + $urandom_range(0, 4)), i == 0, i == 39);
		wait_idle();
	endtask

	// Random strings over small page pools, with noise and frame count changes.
	task automatic test_random_strings();
		logic [lrupr_pkg::PAGE_NUM_W-1:0] pool [12];
		int sent;
		int len;
		int pool_size;
		int i;
		bit noise;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			// Change the frame count every few strings, extremes often.
			if ($urandom_range(0, 2) == 0) begin
				wait_idle();
				case ($urandom_range(0, 5))
					0: write_frame_count(lrupr_pkg::CFG_W'(0));
					1: write_frame_count(lrupr_pkg::CFG_W'(1));
					2: write_frame_count(lrupr_pkg::CFG_W'(lrupr_pkg::FRAMES));
					3: write_frame_count({lrupr_pkg::CFG_W{1'b1}});
					default: write_frame_count(lrupr_pkg::CFG_W'($urandom_range(0, 15)));
				endcase
			end
			// A long stretch without any idling on either side.
			gaps_on = !(sent >= 150 && sent < 300);
			len = $urandom_range(1, 30);
			pool_size = $urandom_range(1, 12);
			for (i = 0; i < 12; i++)
				pool[i] = lrupr_pkg::PAGE_NUM_W'($urandom());
			noise = ($urandom_range(0, 99) < 15);
			for (i = 0; i < len; i++) begin
				if (noise)
					send_ref(lrupr_pkg::PAGE_NUM_W'($urandom()), $urandom_range(0, 7) == 0,
						$urandom_range(0, 7) == 0);
				else
					send_ref(pool[$urandom_range(0, pool_size - 1)], i == 0, i == len - 1);
				sent++;
			end
		end
		gaps_on = 1'b1;
		wait_idle();
	endtask

	// Reset, run each test in turn, then report.
	initial begin
		arst_n <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.page_number <= '0;
		req_ch.first_of_string <= 1'b0;
		req_ch.end_of_string <= 1'b0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.frame_count <= '0;
		gaps_on = 1'b1;
		stall_req = 1'b0;
		clear_frames();
		tbl_frame_count = lrupr_pkg::CFG_RESET;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_fill_hit_evict();
		test_frame_count_limits();
		test_resize_mid_string();
		test_result_backpressure();
		test_random_strings();

		wait_idle();
		if (mismatches == 0 && expected_results.size() == 0)
			$display("[lru_page_replacement_unit] OK");
		else
			$display("[lru_page_replacement_unit] ERROR");
		$finish;
	end

endmodule

### sim.f
hw/rtl/lrupr_pkg.sv
hw/rtl/lrupr_if.sv
hw/rtl/lrupr_cell.sv
hw/rtl/lru_page_replacement_unit.sv
hw/rtl/lrupr_checker.sv
sim/tb_lru_page_replacement_unit.sv
